// ===== rtl/mhpq_pkg.sv =====
// Package for the min-heap priority queue.
// Sizes, entry layout, command/status codes and sequencer states.
// No dependencies; every other file but mhpq_ram uses this one.
package mhpq_pkg;

  // Heap sizing
  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Beat field widths
  localparam int CMD_W    = 2;
  localparam int ID_W     = 16;
  localparam int PRI_W    = 4;
  localparam int STAT_W   = 2;
  localparam int FIDX_W   = 5;
  localparam int TOTAL_W  = 6;

  // One stored heap entry
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_UPDATE = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_MISS  = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_RM_ROOT,
    ST_RM_LAST,
    ST_SCAN,
    ST_SD_LOAD,
    ST_SD_X,
    ST_SD_CHK,
    ST_SD_L,
    ST_SD_R,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/mhpq_if.sv =====
// Valid/ready channel interfaces for the command and result beats.
// Depends on mhpq_pkg for field widths.
interface mhpq_in_if;
  logic                           valid;
  logic                           ready;
  logic [mhpq_pkg::CMD_W-1:0]     cmd;
  logic [mhpq_pkg::ID_W-1:0]      ship_id;
  logic [mhpq_pkg::PRI_W-1:0]     priority_req;

  modport source (output valid, output cmd, output ship_id, output priority_req,
                  input ready);
  modport sink   (input valid, input cmd, input ship_id, input priority_req,
                  output ready);
endinterface

interface mhpq_out_if;
  logic                           valid;
  logic                           ready;
  logic [mhpq_pkg::STAT_W-1:0]    status;
  logic [mhpq_pkg::ID_W-1:0]      out_id;
  logic [mhpq_pkg::PRI_W-1:0]     out_priority;
  logic [mhpq_pkg::FIDX_W-1:0]    found_index;
  logic [mhpq_pkg::TOTAL_W-1:0]   entry_total;

  modport source (output valid, output status, output out_id, output out_priority,
                  output found_index, output entry_total, input ready);
  modport sink   (input valid, input status, input out_id, input out_priority,
                  input found_index, input entry_total, output ready);
endinterface

// ===== rtl/mhpq_ram.sv =====
// Generic single-port-read, single-port-write RAM with registered read data.
// No dependencies.
module mhpq_ram #(
  parameter int  WIDTH = 20,
  parameter int  DEPTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/min_heap_priority_queue.sv =====
// Binary min-heap priority queue: one command beat in, one result beat out. The
// heap lives in a RAM with one read and one write port and registered read
// data, and every command is a walk of a sequencer over that RAM, so the
// read port sets the cost. Insert climbs from the new slot towards the root;
// remove-min sifts the last entry down from the root; search scans the
// entries in index order; update takes its scan plus a full bottom-up
// rebuild. A new command is taken only while the sequencer is idle; the
// result sits in an output register, so the next command may start while it
// waits.
// Depends on mhpq_pkg, mhpq_if and mhpq_ram.
module min_heap_priority_queue (
  input  logic       clk,
  input  logic       rst_n,
  mhpq_in_if.sink    in_if,
  mhpq_out_if.source out_if
);
  import mhpq_pkg::*;

  localparam int CW = IDX_W + 2;  // child index width, holds 2*p+2

  state_t state_r, state_nxt;

  // Command latch
  cmd_t             cmd_r, cmd_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [PRI_W-1:0] pri_r, pri_nxt;

  // Heap bookkeeping
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] ins_c_r, ins_c_nxt;
  logic [IDX_W-1:0] p_r, p_nxt;
  logic [IDX_W-1:0] base_r, base_nxt;
  logic             rebuild_r, rebuild_nxt;
  entry_t           x_r, x_nxt;
  entry_t           left_r, left_nxt;

  // Scan pipeline
  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic [IDX_W-1:0] cmp_r, cmp_nxt;
  logic             pend_r, pend_nxt;

  // Result being built
  status_t           res_status_r, res_status_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic [PRI_W-1:0]  res_pri_r, res_pri_nxt;
  logic [FIDX_W-1:0] res_fidx_r, res_fidx_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  status_t            o_status_r, o_status_nxt;
  logic [ID_W-1:0]    o_id_r, o_id_nxt;
  logic [PRI_W-1:0]   o_pri_r, o_pri_nxt;
  logic [FIDX_W-1:0]  o_fidx_r, o_fidx_nxt;
  logic [TOTAL_W-1:0] o_total_r, o_total_nxt;

  // RAM port
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  entry_t             rdata;

  mhpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rdata = entry_t'(mem_rdata);

  // Shared conditions
  logic             in_fire, out_free, full, empty;
  logic [IDX_W-1:0] start_par, ins_par, ins_par2, rb_start, last_idx;
  logic [CW-1:0]    sd_c, sd_c1, n_ext;
  logic             has_left, has_right, sink, sd_more;
  entry_t           cand;
  logic [IDX_W-1:0] cand_idx;
  logic             scan_hit, scan_miss;

  assign in_fire   = in_if.valid && in_if.ready;
  assign out_free  = !out_valid_r || out_if.ready;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);

  // Insert walk: parent of the hole
  assign start_par = IDX_W'((count_r - CNT_W'(1)) >> 1);
  assign ins_par   = (ins_c_r - IDX_W'(1)) >> 1;
  assign ins_par2  = (ins_par - IDX_W'(1)) >> 1;
  assign last_idx  = IDX_W'(count_r - CNT_W'(1));
  assign rb_start  = (count_r >= CNT_W'(2)) ? IDX_W'((count_r - CNT_W'(2)) >> 1) : '0;

  // Sift-down: children of p and the smaller one
  assign sd_c      = {1'b0, p_r, 1'b1};
  assign sd_c1     = sd_c + CW'(1);
  assign n_ext     = CW'(count_r);
  assign has_left  = (sd_c < n_ext);
  assign has_right = (sd_c1 < n_ext);
  assign sd_more   = rebuild_r && (base_r != '0);

  always_comb begin
    if (state_r == ST_SD_R && rdata.pri < left_r.pri) begin
      cand     = rdata;
      cand_idx = IDX_W'(sd_c1);
    end else if (state_r == ST_SD_R) begin
      cand     = left_r;
      cand_idx = IDX_W'(sd_c);
    end else begin
      cand     = rdata;
      cand_idx = IDX_W'(sd_c);
    end
  end

  assign sink      = (x_r.pri > cand.pri);

  // Scan compare on the entry read last cycle
  assign scan_hit  = pend_r && (rdata.id == id_r);
  assign scan_miss = !scan_hit && (iss_r >= count_r);

  assign in_if.ready         = (state_r == ST_IDLE);
  assign out_if.valid        = out_valid_r;
  assign out_if.status       = o_status_r;
  assign out_if.out_id       = o_id_r;
  assign out_if.out_priority = o_pri_r;
  assign out_if.found_index  = o_fidx_r;
  assign out_if.entry_total  = o_total_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_START;
      end
      ST_START: begin
        unique case (cmd_r)
          CMD_INSERT: state_nxt = (full || empty) ? ST_DONE : ST_INS_CMP;
          CMD_REMOVE: state_nxt = empty ? ST_DONE : ST_RM_ROOT;
          CMD_SEARCH, CMD_UPDATE: state_nxt = ST_SCAN;
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_INS_CMP: begin
        if (rdata.pri > pri_r) begin
          state_nxt = (ins_par == '0) ? ST_INS_PUT : ST_INS_CMP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_INS_PUT: state_nxt = ST_DONE;
      ST_RM_ROOT: state_nxt = ST_RM_LAST;
      ST_RM_LAST: state_nxt = ST_SD_CHK;
      ST_SCAN: begin
        if (scan_hit) begin
          state_nxt = (cmd_r == CMD_UPDATE) ? ST_SD_LOAD : ST_DONE;
        end else if (scan_miss) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SD_LOAD: state_nxt = ST_SD_X;
      ST_SD_X:    state_nxt = ST_SD_CHK;
      ST_SD_CHK: begin
        if (has_left) state_nxt = ST_SD_L;
        else          state_nxt = sd_more ? ST_SD_LOAD : ST_DONE;
      end
      ST_SD_L: begin
        if (has_right) state_nxt = ST_SD_R;
        else if (sink) state_nxt = ST_SD_CHK;
        else           state_nxt = sd_more ? ST_SD_LOAD : ST_DONE;
      end
      ST_SD_R: begin
        if (sink) state_nxt = ST_SD_CHK;
        else      state_nxt = sd_more ? ST_SD_LOAD : ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and RAM controls
  always_comb begin
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    pri_nxt        = pri_r;
    count_nxt      = count_r;
    ins_c_nxt      = ins_c_r;
    p_nxt          = p_r;
    base_nxt       = base_r;
    rebuild_nxt    = rebuild_r;
    x_nxt          = x_r;
    left_nxt       = left_r;
    iss_nxt        = iss_r;
    cmp_nxt        = cmp_r;
    pend_nxt       = pend_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_pri_nxt    = res_pri_r;
    res_fidx_nxt   = res_fidx_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    o_status_nxt   = o_status_r;
    o_id_nxt       = o_id_r;
    o_pri_nxt      = o_pri_r;
    o_fidx_nxt     = o_fidx_r;
    o_total_nxt    = o_total_r;
    mem_we         = 1'b0;
    mem_waddr      = p_r;
    mem_wdata      = x_r;
    mem_re         = 1'b0;
    mem_raddr      = p_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt = cmd_t'(in_if.cmd);
          id_nxt  = in_if.ship_id;
          pri_nxt = in_if.priority_req;
        end
      end
      ST_START: begin
        res_status_nxt = STAT_OK;
        res_id_nxt     = '0;
        res_pri_nxt    = '0;
        res_fidx_nxt   = '0;
        rebuild_nxt    = 1'b0;
        iss_nxt        = '0;
        pend_nxt       = 1'b0;
        unique case (cmd_r)
          CMD_INSERT: begin
            if (full) begin
              res_status_nxt = STAT_FULL;
            end else if (empty) begin
              // First entry goes straight to the root
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = '{id: id_r, pri: pri_r};
              count_nxt = count_r + CNT_W'(1);
            end else begin
              ins_c_nxt = IDX_W'(count_r);
              mem_re    = 1'b1;
              mem_raddr = start_par;
            end
          end
          CMD_REMOVE: begin
            if (empty) begin
              res_status_nxt = STAT_EMPTY;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
            end
          end
          default: ;
        endcase
      end
      // Sift-up: pull larger parents down into the hole
      ST_INS_CMP: begin
        mem_we = 1'b1;
        if (rdata.pri > pri_r) begin
          mem_waddr = ins_c_r;
          mem_wdata = rdata;
          ins_c_nxt = ins_par;
          if (ins_par != '0) begin
            mem_re    = 1'b1;
            mem_raddr = ins_par2;
          end
        end else begin
          mem_waddr = ins_c_r;
          mem_wdata = '{id: id_r, pri: pri_r};
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ST_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = ins_c_r;
        mem_wdata = '{id: id_r, pri: pri_r};
        count_nxt = count_r + CNT_W'(1);
      end
      // Remove: take the root, fetch the last entry
      ST_RM_ROOT: begin
        res_id_nxt  = rdata.id;
        res_pri_nxt = rdata.pri;
        count_nxt   = count_r - CNT_W'(1);
        mem_re      = 1'b1;
        mem_raddr   = last_idx;
      end
      ST_RM_LAST: begin
        x_nxt = rdata;
        p_nxt = '0;
      end
      // Linear scan, one read issued and one compare per cycle
      ST_SCAN: begin
        if (scan_hit) begin
          if (cmd_r == CMD_UPDATE) begin
            mem_we      = 1'b1;
            mem_waddr   = cmp_r;
            mem_wdata   = '{id: rdata.id, pri: pri_r};
            rebuild_nxt = 1'b1;
            base_nxt    = rb_start;
            p_nxt       = rb_start;
          end else begin
            res_fidx_nxt = FIDX_W'(cmp_r);
          end
        end else if (scan_miss) begin
          res_status_nxt = STAT_MISS;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(iss_r);
          cmp_nxt   = IDX_W'(iss_r);
          iss_nxt   = iss_r + CNT_W'(1);
          pend_nxt  = 1'b1;
        end
      end
      ST_SD_LOAD: begin
        mem_re    = 1'b1;
        mem_raddr = p_r;
      end
      ST_SD_X: begin
        x_nxt = rdata;
      end
      // Sift-down with the moving entry held in x_r
      ST_SD_CHK: begin
        if (has_left) begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(sd_c);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = p_r;
          mem_wdata = x_r;
          if (sd_more) begin
            base_nxt = base_r - IDX_W'(1);
            p_nxt    = base_r - IDX_W'(1);
          end
        end
      end
      ST_SD_L, ST_SD_R: begin
        if (state_r == ST_SD_L) left_nxt = rdata;
        if (state_r == ST_SD_L && has_right) begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(sd_c1);
        end else if (sink) begin
          mem_we    = 1'b1;
          mem_waddr = p_r;
          mem_wdata = cand;
          p_nxt     = cand_idx;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = p_r;
          mem_wdata = x_r;
          if (sd_more) begin
            base_nxt = base_r - IDX_W'(1);
            p_nxt    = base_r - IDX_W'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = res_status_r;
          o_id_nxt      = res_id_r;
          o_pri_nxt     = res_pri_r;
          o_fidx_nxt    = res_fidx_r;
          o_total_nxt   = TOTAL_W'(count_r);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rebuild_r   <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      rebuild_r   <= rebuild_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    id_r         <= id_nxt;
    pri_r        <= pri_nxt;
    ins_c_r      <= ins_c_nxt;
    p_r          <= p_nxt;
    base_r       <= base_nxt;
    x_r          <= x_nxt;
    left_r       <= left_nxt;
    iss_r        <= iss_nxt;
    cmp_r        <= cmp_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_pri_r    <= res_pri_nxt;
    res_fidx_r   <= res_fidx_nxt;
    o_status_r   <= o_status_nxt;
    o_id_r       <= o_id_nxt;
    o_pri_r      <= o_pri_nxt;
    o_fidx_r     <= o_fidx_nxt;
    o_total_r    <= o_total_nxt;
  end

endmodule

// ===== rtl/mhpq_checker.sv =====
// Port-level checks for the min-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and min_heap_priority_queue.
module mhpq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mhpq_pkg::STAT_W-1:0]  status,
  input logic [mhpq_pkg::ID_W-1:0]    out_id,
  input logic [mhpq_pkg::PRI_W-1:0]   out_priority,
  input logic [mhpq_pkg::TOTAL_W-1:0] entry_total
);
  import mhpq_pkg::*;

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_id)
      && $stable(entry_total))
    else $error("result beat changed while stalled");

  // Count never exceeds capacity
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> entry_total <= TOTAL_W'(CAPACITY))
    else $error("entry_total above capacity");

  // Full and empty reports agree with the count
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STAT_FULL |-> entry_total == TOTAL_W'(CAPACITY))
    else $error("full reported with room left");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STAT_EMPTY |-> entry_total == '0)
    else $error("empty reported with entries held");

  // Only a good remove carries an entry
  a_noent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != STAT_OK |-> out_id == '0 && out_priority == '0)
    else $error("entry fields set on a failed command");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .status       (out_if.status),
  .out_id       (out_if.out_id),
  .out_priority (out_if.out_priority),
  .entry_total  (out_if.entry_total)
);

// ===== test/tb_min_heap_priority_queue.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for min_heap_priority_queue: a directed table, then random phases.
// Expected results come from a shadow heap kept in the bench. Uses mhpq_pkg, mhpq_if and the RTL.
module tb_min_heap_priority_queue;
  import mhpq_pkg::*;

  // Watchdog limit on cycles without any beat, and the quiet time at the end
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE_LEN   = 300;
  localparam int RANDOM_ITEMS = 550;
  localparam int HOLD_AFTER   = 150;
  localparam int HOLD_LEN     = 300;

  typedef struct {
    status_t            status;
    logic [ID_W-1:0]    out_id;
    logic [PRI_W-1:0]   out_priority;
    logic [FIDX_W-1:0]  found_index;
    logic [TOTAL_W-1:0] entry_total;
  } result_t;

  typedef struct {
    cmd_t             cmd;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    bit               typed;
    result_t          want;
  } dir_row_t;

  typedef enum {PH_FILL, PH_MIX, PH_DRAIN, PH_MIX2} phase_t;

  logic clk;
  logic rst_n;

  mhpq_in_if  in_bus ();
  mhpq_out_if out_bus ();

  min_heap_priority_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  // Shadow copy of the heap
  entry_t  shadow_heap [CAPACITY];
  int      shadow_count;
  result_t pending_results [$];
  int      mismatch_count;
  int      results_seen;
  dir_row_t dir_rows [$];
  logic [ID_W-1:0] id_pool [8];

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sift an entry down; right child only when strictly smaller
  function automatic void shadow_sift_down(int start, int n);
    int p;
    int c;
    entry_t t;
    p = start;
    c = 2 * p + 1;
    while (c < n) begin
      if (c + 1 < n && shadow_heap[c + 1].pri < shadow_heap[c].pri) c++;
      if (shadow_heap[p].pri > shadow_heap[c].pri) begin
        t = shadow_heap[p];
        shadow_heap[p] = shadow_heap[c];
        shadow_heap[c] = t;
        p = c;
        c = 2 * p + 1;
      end else begin
        break;
      end
    end
  endfunction

  // Lowest index holding this id, or -1
  function automatic int shadow_find(logic [ID_W-1:0] id);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_heap[i].id == id) return i;
    end
    return -1;
  endfunction

  // Apply one command to the shadow heap and return the result it should give
  function automatic result_t predict_heap_cmd(cmd_t c, logic [ID_W-1:0] id,
                                               logic [PRI_W-1:0] pri);
    result_t r;
    int slot;
    int hit;
    r.status       = STAT_OK;
    r.out_id       = '0;
    r.out_priority = '0;
    r.found_index  = '0;
    case (c)
      CMD_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          slot = shadow_count;
          while (slot > 0 && shadow_heap[(slot - 1) / 2].pri > pri) begin
            shadow_heap[slot] = shadow_heap[(slot - 1) / 2];
            slot = (slot - 1) / 2;
          end
          shadow_heap[slot].id  = id;
          shadow_heap[slot].pri = pri;
          shadow_count++;
        end
      end
      CMD_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.out_id       = shadow_heap[0].id;
          r.out_priority = shadow_heap[0].pri;
          shadow_count--;
          shadow_heap[0] = shadow_heap[shadow_count];
          shadow_sift_down(0, shadow_count);
        end
      end
      CMD_SEARCH: begin
        hit = shadow_find(id);
        if (hit < 0) r.status = STAT_MISS;
        else r.found_index = FIDX_W'(hit);
      end
      default: begin
        hit = shadow_find(id);
        if (hit < 0) begin
          r.status = STAT_MISS;
        end else begin
          // New priority, then a full bottom-up rebuild
          shadow_heap[hit].pri = pri;
          for (int p = (shadow_count >= 2) ? (shadow_count - 2) / 2 : 0; p >= 0; p--)
            shadow_sift_down(p, shadow_count);
        end
      end
    endcase
    r.entry_total = TOTAL_W'(shadow_count);
    return r;
  endfunction

  // Idle stretch length: mostly short, a few long
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one command beat, predict on acceptance, then idle for gap cycles
  task automatic send_beat(cmd_t c, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri,
                           bit typed, result_t want, int gap);
    result_t pred;
    @(negedge clk);
    in_bus.valid        <= 1'b1;
    in_bus.cmd          <= c;
    in_bus.ship_id      <= id;
    in_bus.priority_req <= pri;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    pred = predict_heap_cmd(c, id, pri);
    pending_results.push_back(typed ? want : pred);
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic add_row(cmd_t c, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri,
                         bit typed, status_t st, int total);
    dir_row_t row;
    row.cmd                = c;
    row.id                 = id;
    row.pri                = pri;
    row.typed              = typed;
    row.want.status        = st;
    row.want.out_id        = '0;
    row.want.out_priority  = '0;
    row.want.found_index   = '0;
    row.want.entry_total   = TOTAL_W'(total);
    dir_rows.push_back(row);
  endtask

  // Result checker: every beat against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t e;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation pending");
        mismatch_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_bus.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_bus.status);
          mismatch_count++;
        end
        if (out_bus.out_id !== e.out_id) begin
          $error("out_id: expected %0h, got %0h", e.out_id, out_bus.out_id);
          mismatch_count++;
        end
        if (out_bus.out_priority !== e.out_priority) begin
          $error("out_priority: expected %0d, got %0d", e.out_priority, out_bus.out_priority);
          mismatch_count++;
        end
        if (out_bus.found_index !== e.found_index) begin
          $error("found_index: expected %0d, got %0d", e.found_index, out_bus.found_index);
          mismatch_count++;
        end
        if (out_bus.entry_total !== e.entry_total) begin
          $error("entry_total: expected %0d, got %0d", e.entry_total, out_bus.entry_total);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long without any beat on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
          (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Result receiver: random stalls, calm stretches, one long hold-off
  initial begin : receiver
    int  stall_left;
    int  hold_left;
    int  mode_left;
    bit  calm;
    bit  held;
    stall_left = 0;
    hold_left  = 0;
    mode_left  = 0;
    calm       = 1'b0;
    held       = 1'b0;
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (mode_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(32, 128);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        stall_left = idle_len() - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    result_t    none;
    phase_t     ph;
    int         sent;
    int         ph_len;
    int         r;
    int         gap;
    bit         no_gaps;
    cmd_t       c;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;

    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.cmd          = CMD_INSERT;
    in_bus.ship_id      = '0;
    in_bus.priority_req = '0;
    shadow_count        = 0;
    mismatch_count      = 0;
    results_seen        = 0;
    none                = '{STAT_OK, '0, '0, '0, '0};

    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int k = 2; k < 8; k++) id_pool[k] = ID_W'($urandom_range(0, 65535));

    // Directed table; typed rows carry their own expectation
    add_row(CMD_REMOVE, 16'h0000, 4'd0,  1, STAT_EMPTY, 0);
    add_row(CMD_SEARCH, 16'h1234, 4'd0,  1, STAT_MISS,  0);
    add_row(CMD_UPDATE, 16'h1234, 4'd5,  1, STAT_MISS,  0);
    add_row(CMD_INSERT, 16'hFFFF, 4'd15, 1, STAT_OK,    1);
    add_row(CMD_INSERT, 16'h0000, 4'd0,  1, STAT_OK,    2);
    add_row(CMD_SEARCH, 16'hFFFF, 4'd0,  0, STAT_OK,    0);
    add_row(CMD_INSERT, 16'h00A5, 4'd7,  0, STAT_OK,    0);
    // equal priority must not swap
    add_row(CMD_INSERT, 16'h5A5A, 4'd7,  0, STAT_OK,    0);
    // duplicate id: search and update hit the lowest index
    add_row(CMD_INSERT, 16'h00A5, 4'd3,  0, STAT_OK,    0);
    add_row(CMD_SEARCH, 16'h00A5, 4'd0,  0, STAT_OK,    0);
    add_row(CMD_UPDATE, 16'h00A5, 4'd15, 0, STAT_OK,    0);
    // priority 15 stays at the last slot; update must still reach it
    add_row(CMD_INSERT, 16'hBEEF, 4'd15, 0, STAT_OK,    0);
    add_row(CMD_UPDATE, 16'hBEEF, 4'd0,  0, STAT_OK,    0);
    add_row(CMD_SEARCH, 16'h7777, 4'd0,  1, STAT_MISS,  6);
    add_row(CMD_UPDATE, 16'h7777, 4'd9,  1, STAT_MISS,  6);
    repeat (6) add_row(CMD_REMOVE, 16'h0000, 4'd0, 0, STAT_OK, 0);
    add_row(CMD_REMOVE, 16'h0000, 4'd0,  1, STAT_EMPTY, 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      send_beat(dir_rows[i].cmd, dir_rows[i].id, dir_rows[i].pri,
                dir_rows[i].typed, dir_rows[i].want,
                ($urandom_range(0, 1) == 0) ? 0 : idle_len());

    // Random phases: fill, mix, drain, mix, repeated
    sent = 0;
    ph   = PH_FILL;
    while (sent < RANDOM_ITEMS) begin
      ph_len  = $urandom_range(30, 60);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ph_len && sent < RANDOM_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        case (ph)
          PH_FILL:  c = (r < 75) ? CMD_INSERT : (r < 85) ? CMD_REMOVE :
                        (r < 93) ? CMD_SEARCH : CMD_UPDATE;
          PH_DRAIN: c = (r < 70) ? CMD_REMOVE : (r < 80) ? CMD_INSERT :
                        (r < 90) ? CMD_SEARCH : CMD_UPDATE;
          default:  c = cmd_t'($urandom_range(0, 3));
        endcase
        // Ids: often from a small pool or from a held entry, so hits are common
        if ((c == CMD_SEARCH || c == CMD_UPDATE) && shadow_count > 0 &&
            $urandom_range(0, 99) < 60)
          id = shadow_heap[$urandom_range(0, shadow_count - 1)].id;
        else if ($urandom_range(0, 99) < 65)
          id = id_pool[$urandom_range(0, 7)];
        else
          id = ID_W'($urandom_range(0, 65535));
        pri = PRI_W'($urandom_range(0, 15));
        gap = (no_gaps || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        send_beat(c, id, pri, 0, none, gap);
        sent++;
      end
      // After a drain, pause until every result is back
      if (ph == PH_DRAIN) begin
        @(negedge clk);
        in_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      ph = (ph == PH_MIX2) ? PH_FILL : phase_t'(ph + 1);
    end

    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
